/* rtl/bsfe_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and helpers for the byte-stuffed frame encoder
package bsfe_pkg;

    // framing marks
    localparam logic [7:0] HEAD_MARK = 8'hAA;
    localparam logic [7:0] TAIL_MARK = 8'h55;
    localparam logic [7:0] ESC_MARK  = 8'hA5;

    // longest run of line bytes caused by one payload beat
    localparam int RUN_MAX   = 8;
    localparam int RUN_IDX_W = $clog2(RUN_MAX);
    localparam int RUN_POS_W = RUN_IDX_W + 1;

    // one expanded run of line bytes, ready to be sent out
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_IDX_W-1:0]    last_idx;
        logic                    frame_close;
    } run_t;

    // byte collides with a framing mark and needs an escape in front
    function automatic logic needs_escape(input logic [7:0] b);
        return (b == ESC_MARK) || (b == HEAD_MARK) || (b == TAIL_MARK);
    endfunction

endpackage

/* rtl/bsfe_expand.sv */
`timescale 1ns / 1ps
// frame state and expansion of one payload beat into its run of line bytes
module bsfe_expand (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         payload_byte,
    input  logic               last_byte,
    input  logic               take,
    output bsfe_pkg::run_t     run
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] sum_add;

    // checksum including this beat
    assign sum_add = sum_reg + payload_byte;

    // build the run: header at frame start, escaped byte, and on the last byte the escaped checksum and tail
    always_comb
    begin
        logic [bsfe_pkg::RUN_POS_W-1:0] pos;
        pos = '0;
        run.bytes = '0;
        if (!in_frame_reg)
        begin
            run.bytes[0] = bsfe_pkg::HEAD_MARK;
            run.bytes[1] = bsfe_pkg::HEAD_MARK;
            pos = bsfe_pkg::RUN_POS_W'(2);
        end
        if (bsfe_pkg::needs_escape(payload_byte))
        begin
            run.bytes[pos[bsfe_pkg::RUN_IDX_W-1:0]] = bsfe_pkg::ESC_MARK;
            pos = pos + 1'b1;
        end
        run.bytes[pos[bsfe_pkg::RUN_IDX_W-1:0]] = payload_byte;
        pos = pos + 1'b1;
        if (last_byte)
        begin
            if (bsfe_pkg::needs_escape(sum_add))
            begin
                run.bytes[pos[bsfe_pkg::RUN_IDX_W-1:0]] = bsfe_pkg::ESC_MARK;
                pos = pos + 1'b1;
            end
            run.bytes[pos[bsfe_pkg::RUN_IDX_W-1:0]] = sum_add;
            pos = pos + 1'b1;
            run.bytes[pos[bsfe_pkg::RUN_IDX_W-1:0]] = bsfe_pkg::TAIL_MARK;
            pos = pos + 1'b1;
            run.bytes[pos[bsfe_pkg::RUN_IDX_W-1:0]] = bsfe_pkg::TAIL_MARK;
            pos = pos + 1'b1;
        end
        run.last_idx    = bsfe_pkg::RUN_IDX_W'(pos - 1'b1);
        run.frame_close = last_byte;
    end

    // frame state after this beat
    always_comb
    begin
        in_frame_next = in_frame_reg;
        sum_next      = sum_reg;
        if (take)
        begin
            in_frame_next = !last_byte;
            sum_next      = last_byte ? 8'h00 : sum_add;
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            sum_reg      <= 8'h00;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

/* rtl/bsfe_emit.sv */
`timescale 1ns / 1ps
// run register and sender for the expanded line bytes, one byte per cycle while out_ready is high
module bsfe_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  bsfe_pkg::run_t     run_in,
    input  logic               load,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         line_byte,
    output logic               run_end,
    output logic               frame_end
);

    bsfe_pkg::run_t                run_reg;
    bsfe_pkg::run_t                run_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [bsfe_pkg::RUN_IDX_W-1:0] idx_reg;
    logic [bsfe_pkg::RUN_IDX_W-1:0] idx_next;
    logic                          beat;

    // current byte of the held run
    assign out_valid = valid_reg;
    assign line_byte = run_reg.bytes[idx_reg];
    assign run_end   = (idx_reg == run_reg.last_idx);
    assign frame_end = run_end && run_reg.frame_close;
    assign beat      = valid_reg && out_ready;

    // a new run may load when empty or when the final byte leaves now
    assign free = !valid_reg || (out_ready && run_end);

    // sender control
    always_comb
    begin
        run_next   = run_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (beat)
        begin
            idx_next = idx_reg + 1'b1;
            if (run_end)
            begin
                valid_next = 1'b0;
                idx_next   = '0;
            end
        end
        if (load)
        begin
            run_next   = run_in;
            valid_next = 1'b1;
            idx_next   = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // run payload register
    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
    end

    // index never passes the end of the held run
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg <= run_reg.last_idx))
        else $error("run index beyond end of run");

    // a closing byte is always a tail mark at the end of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && frame_end) |-> (run_end && line_byte == bsfe_pkg::TAIL_MARK))
        else $error("frame end not on final tail byte");

    // after the final byte of a run leaves, the next run starts at its first byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (beat && run_end) |=> (idx_reg == '0))
        else $error("run index not restarted");

    // a load only happens when the register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("run loaded while still busy");

endmodule

/* rtl/byte_stuffed_frame_encoder.sv */
`timescale 1ns / 1ps
// top level of the byte-stuffed frame encoder
// Takes one payload beat and sends 1 to 8 line bytes for it, one byte per
// cycle while out_ready is high: the 0xAA 0xAA header before a frame's first
// byte, an 0xA5 escape before any byte equal to 0xA5, 0xAA or 0x55, and after
// the last byte the escaped modulo-256 checksum and the 0x55 0x55 tail. A beat
// is expanded combinationally into a run register; the next beat is taken in
// the same cycle the final byte of the current run is taken, so the single
// output byte per cycle, held back by out_ready, sets the rate of beats.
module byte_stuffed_frame_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] payload_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       run_end,
    output logic       frame_end
);

    bsfe_pkg::run_t run;
    logic           take;
    logic           free;

    // input beat handshake
    assign in_ready = free;
    assign take     = in_valid && free;

    // frame state and run expansion
    bsfe_expand u_expand (
        .clk          (clk),
        .rst_n        (rst_n),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .take         (take),
        .run          (run)
    );

    // run register and byte sender
    bsfe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_in    (run),
        .load      (take),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .line_byte (line_byte),
        .run_end   (run_end),
        .frame_end (frame_end)
    );

endmodule
